### rtl/ealc_pkg.sv
`default_nettype none

package ealc_pkg;

  // Input item: one byte of the list, or an empty item that adds no byte; last ends the list
  typedef struct packed {
    logic [7:0] ch;
    logic       no_char;
    logic       last;
  } in_item_t;

  // Result item: verdict on the whole list
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] address_count;
  } out_item_t;

  // Verdict codes; among the failure codes the lower code wins
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
  localparam logic [1:0] STATUS_MULTI_AT   = 2'd2;
  localparam logic [1:0] STATUS_BAD_ADDR   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TLD_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TLD_MAX    = 2'd2;

  localparam logic [8:0] MAX_LENGTH_RESET = 9'd256;
  localparam logic [2:0] TLD_MIN_RESET    = 3'd2;
  localparam logic [2:0] TLD_MAX_RESET    = 3'd4;

  // Position inside the current address
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_NAME   = 3'b010,
    PH_DOMAIN = 3'b100
  } phase_e;

  // Running flags of the list and of the current address
  typedef struct packed {
    logic [1:0] at_cnt;
    logic       comma_seen;
    logic       failed;
    logic [7:0] addr_cnt;
    phase_e     phase;
    logic       name_valid;
    logic [1:0] label_cnt;
    logic [3:0] cur_len;
    logic       cur_alpha;
    logic [3:0] fin_len;
    logic       fin_alpha;
  } chk_t;

  localparam chk_t CHK_RESET = '{
    at_cnt:     2'd0,
    comma_seen: 1'b0,
    failed:     1'b0,
    addr_cnt:   8'd0,
    phase:      PH_IDLE,
    name_valid: 1'b0,
    label_cnt:  2'd0,
    cur_len:    4'd0,
    cur_alpha:  1'b1,
    fin_len:    4'd0,
    fin_alpha:  1'b0
  };

endpackage

`default_nettype wire

### rtl/ealc_step.sv
`default_nettype none

module ealc_step (
  input  ealc_pkg::in_item_t item_i,
  input  ealc_pkg::chk_t     state_i,
  input  logic [2:0]         tld_min_i,
  input  logic [2:0]         tld_max_i,
  output ealc_pkg::chk_t     state_o
);
  import ealc_pkg::*;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic chk_t clear_token(input chk_t s);
    chk_t r;
    r            = s;
    r.phase      = PH_IDLE;
    r.name_valid = 1'b0;
    r.label_cnt  = 2'd0;
    r.cur_len    = 4'd0;
    r.cur_alpha  = 1'b1;
    r.fin_len    = 4'd0;
    r.fin_alpha  = 1'b0;
    return r;
  endfunction

  function automatic chk_t close_label(input chk_t s);
    chk_t r;
    r = s;
    if (r.cur_len != 4'd0) begin
      r.fin_len   = r.cur_len;
      r.fin_alpha = r.cur_alpha;
      if (r.label_cnt < 2'd2) r.label_cnt = r.label_cnt + 2'd1;
    end
    r.cur_len   = 4'd0;
    r.cur_alpha = 1'b1;
    return r;
  endfunction

  function automatic chk_t end_token(input chk_t s, input logic [2:0] mn,
                                     input logic [2:0] mx);
    chk_t r;
    r = s;
    if (r.phase != PH_IDLE) begin
      if (r.addr_cnt < 8'd128) r.addr_cnt = r.addr_cnt + 8'd1;
      if (r.phase == PH_NAME) begin
        r.failed = 1'b1;
      end else begin
        r = close_label(r);
        if (r.label_cnt < 2'd2 || !r.fin_alpha ||
            r.fin_len < {1'b0, mn} || r.fin_len > {1'b0, mx}) r.failed = 1'b1;
      end
      r = clear_token(r);
    end
    return r;
  endfunction

  logic [7:0] c;
  chk_t       s;

  always_comb begin
    c = item_i.ch;
    s = state_i;
    // Fold one byte into the running flags
    if (!item_i.no_char) begin
      if (c == "@" && s.at_cnt < 2'd2) s.at_cnt = s.at_cnt + 2'd1;
      if (c == ",") begin
        s.comma_seen = 1'b1;
        s = end_token(s, tld_min_i, tld_max_i);
      end else begin
        if (s.phase == PH_IDLE) s.phase = PH_NAME;
        if (s.phase == PH_NAME) begin
          if (c == "@") begin
            if (!s.name_valid) s.failed = 1'b1;
            s.phase = PH_DOMAIN;
          end else if (is_space(c) && !s.name_valid) begin
            // skip leading whitespace
          end else if (is_alnum(c) || c == "." || c == "_" || c == "%" ||
                       c == "+" || c == "-") begin
            s.name_valid = 1'b1;
          end else begin
            s.failed = 1'b1;
          end
        end else begin
          if (c == ".") begin
            s = close_label(s);
          end else begin
            if (!(is_alnum(c) || c == "-")) s.failed = 1'b1;
            if (s.cur_len < 4'd8) s.cur_len = s.cur_len + 4'd1;
            if (!is_alpha(c)) s.cur_alpha = 1'b0;
          end
        end
      end
    end
    // Close the open address at the end of the list
    if (item_i.last) s = end_token(s, tld_min_i, tld_max_i);
    state_o = s;
  end

endmodule

`default_nettype wire

### rtl/email_address_list_checker_core.sv
// Checks a comma-separated list of e-mail addresses, one byte per item.
// Input channel: in_valid_i / in_ready_o carry in_item_i (ch, no_char, last).
// An item with no_char set adds no byte; the item with last set closes the
// list and causes exactly one result item on out_valid_o / out_ready_i:
// status (ok, bad length, several at-signs without comma, bad address) and
// the count of non-empty addresses.
// Throughput is one item per clock: the input register and the result
// register each decouple a stage, and a new item enters every cycle
// unless an unread result waits and another last item needs its register.
// When the last item is accepted it is held in the input register, and the
// verdict is loaded into the result register as that item advances.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes one of max_length,
// tld_min and tld_max per write; write them only while the block is idle.
// Reset loads max_length 256, tld_min 2, tld_max 4 and clears all flags;
// the flags clear again after each result. A stalled receiver holds the
// result, and the block stops taking input once a second last item arrives.
`default_nettype none

module email_address_list_checker_core #(
  parameter int unsigned MAX_STRING = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ealc_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ealc_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [ealc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ealc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ealc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_STRING + 2);
  localparam int unsigned LW = (CW > 9) ? CW : 9;

  logic [8:0]    max_length_q;
  logic [2:0]    tld_min_q, tld_max_q;
  logic          in_vld_q;
  in_item_t      in_item_q;
  logic          out_vld_q;
  out_item_t     out_item_q, out_item_d;
  chk_t          chk_q, chk_d, chk_step;
  logic [CW-1:0] char_cnt_q, char_cnt_d, char_cnt_step;
  logic [LW-1:0] limit, cnt_ext;
  logic          advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RESET;
      tld_min_q    <= TLD_MIN_RESET;
      tld_max_q    <= TLD_MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_LENGTH: max_length_q <= cfg_data_i;
        REG_TLD_MIN:    tld_min_q    <= cfg_data_i[2:0];
        REG_TLD_MAX:    tld_max_q    <= cfg_data_i[2:0];
        default:        ;
      endcase
    end
  end

  // Advance the held item unless it would overwrite a waiting result
  assign advance    = in_vld_q && (!in_item_q.last || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_item_q <= in_item_i;
  end

  ealc_step u_step (
    .item_i    (in_item_q),
    .state_i   (chk_q),
    .tld_min_i (tld_min_q),
    .tld_max_i (tld_max_q),
    .state_o   (chk_step)
  );

  // Count bytes, saturating just above the largest string
  always_comb begin
    char_cnt_step = char_cnt_q;
    if (!in_item_q.no_char && char_cnt_q <= CW'(MAX_STRING))
      char_cnt_step = char_cnt_q + CW'(1);
  end

  // Pick the verdict, lower failure code first, else ok
  always_comb begin
    limit   = (LW'(max_length_q) < LW'(MAX_STRING)) ? LW'(max_length_q)
                                                     : LW'(MAX_STRING);
    cnt_ext = LW'(char_cnt_step);
    out_item_d.address_count = chk_step.addr_cnt;
    if (cnt_ext == '0 || cnt_ext > limit) begin
      out_item_d.status = STATUS_BAD_LENGTH;
    end else if (chk_step.at_cnt == 2'd2 && !chk_step.comma_seen) begin
      out_item_d.status = STATUS_MULTI_AT;
    end else if (chk_step.failed) begin
      out_item_d.status = STATUS_BAD_ADDR;
    end else begin
      out_item_d.status = STATUS_OK;
    end
  end

  // Drop all flags after the last item
  always_comb begin
    chk_d      = chk_q;
    char_cnt_d = char_cnt_q;
    if (advance) begin
      if (in_item_q.last) begin
        chk_d      = CHK_RESET;
        char_cnt_d = '0;
      end else begin
        chk_d      = chk_step;
        char_cnt_d = char_cnt_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q      <= CHK_RESET;
      char_cnt_q <= '0;
    end else begin
      chk_q      <= chk_d;
      char_cnt_q <= char_cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_item_q.last) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_item_q.last) out_item_q <= out_item_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
